// ----- rtl/core/stereo_downmix_level_meter_defines.svh -----
// assertion macros shared by the downmix level meter rtl
`ifndef STEREO_DOWNMIX_LEVEL_METER_DEFINES_SVH
`define STEREO_DOWNMIX_LEVEL_METER_DEFINES_SVH

// property checked on every clock edge outside reset
`define SDLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define SDLM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/sdlm_pkg.sv -----
// types and constants shared by the downmix level meter modules
package sdlm_pkg;

  localparam logic [15:0] CAPACITY_RESET = 16'd48000;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_LEFT   = 2'd1;
  localparam logic [1:0] KIND_RIGHT  = 2'd2;
  localparam logic [1:0] KIND_MONO   = 2'd3;

  localparam logic [1:0] METER_LEFT  = 2'd0;
  localparam logic [1:0] METER_RIGHT = 2'd1;
  localparam logic [1:0] METER_MONO  = 2'd2;

  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic [31:0]        sum;
  } meter_t;

  // one queue entry per item that gives results
  typedef struct packed {
    logic               has_sample;
    logic               has_report;
    logic signed [15:0] mono;
    logic [15:0]        kept;
    logic               full;
    meter_t [2:0]       meters;
  } entry_t;

endpackage

// ----- rtl/core/sdlm_if.sv -----
// valid/ready channels for stereo frames and output records
interface frame_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               first_frame;
  logic               last_frame;

  modport source (output valid, left_sample, right_sample, first_frame, last_frame,
                  input ready);
  modport sink (input valid, left_sample, right_sample, first_frame, last_frame,
                output ready);
endinterface

interface record_if;
  logic               valid;
  logic               ready;
  logic [1:0]         record_kind;
  logic signed [15:0] value_or_minimum;
  logic signed [15:0] peak_maximum;
  logic [15:0]        average_magnitude;
  logic [15:0]        kept_frames;
  logic               buffer_full;
  logic               last_of_run;

  modport source (output valid, record_kind, value_or_minimum, peak_maximum,
                  average_magnitude, kept_frames, buffer_full, last_of_run,
                  input ready);
  modport sink (input valid, record_kind, value_or_minimum, peak_maximum,
                average_magnitude, kept_frames, buffer_full, last_of_run,
                output ready);
endinterface

// ----- rtl/core/sdlm_front.sv -----
// front end: accepts frames, picks the mono sample and updates the meters
module sdlm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [15:0]      cfg_data,
  frame_if.sink            frames,
  input  logic             queue_full,
  output logic             push,
  output sdlm_pkg::entry_t push_data
);
  import sdlm_pkg::*;

  function automatic logic [16:0] magnitude(input logic signed [15:0] v);
    logic [16:0] x;
    x = 17'({v[15], v});
    return v[15] ? 17'(-x) : x;
  endfunction

  function automatic meter_t meter_add(input meter_t m, input logic signed [15:0] v,
                                       input logic [16:0] mag);
    meter_t r;
    r = m;
    if ($signed(v) < $signed(m.low)) r.low = v;
    if ($signed(v) > $signed(m.high)) r.high = v;
    r.sum = m.sum + 32'(mag);
    return r;
  endfunction

  logic [15:0]        capacity;
  meter_t [2:0]       meters;
  logic [15:0]        frame_total;

  logic               accept;
  meter_t [2:0]       base;
  meter_t [2:0]       added;
  meter_t [2:0]       meters_next;
  logic [15:0]        total_base;
  logic [15:0]        total_next;
  logic               keep;
  logic [16:0]        mag_l;
  logic [16:0]        mag_r;
  logic               pick_left;
  logic signed [15:0] mono;
  logic [16:0]        mag_m;

  assign frames.ready = !queue_full;
  assign accept       = frames.valid && frames.ready;

  always_comb begin
    // a first flag clears the statistics before this frame counts
    base       = frames.first_frame ? '0 : meters;
    total_base = frames.first_frame ? '0 : frame_total;
    keep       = total_base < capacity;

    mag_l     = magnitude(frames.left_sample);
    mag_r     = magnitude(frames.right_sample);
    pick_left = mag_l >= mag_r;
    mono      = pick_left ? frames.left_sample : frames.right_sample;
    mag_m     = pick_left ? mag_l : mag_r;

    added[METER_LEFT]  = meter_add(base[METER_LEFT], frames.left_sample, mag_l);
    added[METER_RIGHT] = meter_add(base[METER_RIGHT], frames.right_sample, mag_r);
    added[METER_MONO]  = meter_add(base[METER_MONO], mono, mag_m);

    meters_next = keep ? added : base;
    total_next  = keep ? total_base + 16'd1 : total_base;

    push                  = accept && (keep || frames.last_frame);
    push_data.has_sample  = keep;
    push_data.has_report  = frames.last_frame;
    push_data.mono        = mono;
    push_data.kept        = total_next;
    push_data.full        = total_next >= capacity;
    push_data.meters      = meters_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAPACITY_RESET;
      meters      <= '0;
      frame_total <= '0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        meters      <= meters_next;
        frame_total <= total_next;
      end
    end
  end

endmodule

// ----- rtl/core/sdlm_queue.sv -----
// short fifo of pending work between the front and back ends
`include "stereo_downmix_level_meter_defines.svh"

module sdlm_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sdlm_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output sdlm_pkg::entry_t pop_data,
  output logic             empty
);
  import sdlm_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `SDLM_ASSERT_IMPL(a_push_has_room, push, !full, "queue push while full")
  `SDLM_ASSERT_IMPL(a_pop_has_entry, pop, !empty, "queue pop while empty")

endmodule

// ----- rtl/core/sdlm_div.sv -----
// restoring divider, one quotient bit per cycle
module sdlm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  import sdlm_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [15:0]       rem;
  logic [31:0]       quo;
  logic [15:0]       den;

  logic [16:0]       trial;
  logic              fits;
  logic [16:0]       diff;

  assign trial    = {rem, quo[31]};
  assign fits     = trial >= {1'b0, den};
  assign diff     = trial - {1'b0, den};
  assign quotient = quo[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      steps <= STEP_W'(DIV_STEPS);
      rem   <= '0;
      quo   <= dividend;
      den   <= divisor;
    end else if (busy) begin
      steps <= steps - 1'b1;
      rem   <= fits ? diff[15:0] : trial[15:0];
      quo   <= {quo[30:0], fits};
    end
  end

endmodule

// ----- rtl/core/sdlm_back.sv -----
// back end: emits the sample and report records of each queued entry
`include "stereo_downmix_level_meter_defines.svh"

module sdlm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  sdlm_pkg::entry_t pop_data,
  output logic             pop,
  record_if.source         records
);
  import sdlm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEND = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]         state;
  logic [1:0]         kind;
  entry_t             cur;
  logic signed [15:0] value;
  logic signed [15:0] peak;
  logic [15:0]        average;
  logic               last;

  entry_t             src;
  logic               div_start;
  logic [1:0]         div_kind;
  meter_t             div_meter;
  meter_t             rpt_meter;
  logic               div_done;
  logic [15:0]        div_q;

  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    div_kind  = kind + 2'd1;
    src       = cur;
    case (state)
      ST_IDLE: begin
        src = pop_data;
        if (!empty) begin
          pop = 1'b1;
          if (!pop_data.has_sample) begin
            div_start = 1'b1;
            div_kind  = KIND_LEFT;
          end
        end
      end
      ST_SEND: begin
        // after a sample, reports follow only when the item asked for them
        if (records.ready && kind != KIND_MONO && (kind != KIND_SAMPLE || cur.has_report)) begin
          div_start = 1'b1;
        end
      end
      default: ;
    endcase
    div_meter = src.meters[div_kind - 2'd1];
    rpt_meter = cur.meters[kind - 2'd1];
  end

  sdlm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_meter.sum),
    .divisor  (src.kept),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            cur <= pop_data;
            if (pop_data.has_sample) begin
              kind    <= KIND_SAMPLE;
              value   <= pop_data.mono;
              peak    <= '0;
              average <= '0;
              last    <= !pop_data.has_report;
              state   <= ST_SEND;
            end else begin
              kind  <= KIND_LEFT;
              state <= ST_DIV;
            end
          end
        end
        ST_SEND: begin
          if (records.ready) begin
            if (div_start) begin
              kind  <= div_kind;
              state <= ST_DIV;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            value   <= rpt_meter.low;
            peak    <= rpt_meter.high;
            average <= (cur.kept == '0) ? '0 : div_q;
            last    <= kind == KIND_MONO;
            state   <= ST_SEND;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign records.valid             = state == ST_SEND;
  assign records.record_kind       = kind;
  assign records.value_or_minimum  = value;
  assign records.peak_maximum      = peak;
  assign records.average_magnitude = average;
  assign records.kept_frames       = cur.kept;
  assign records.buffer_full       = cur.full;
  assign records.last_of_run       = last;

  `SDLM_ASSERT_IMPL(a_div_done_in_div, div_done, state == ST_DIV,
                    "divider finished outside the divide state")
  `SDLM_ASSERT_IMPL(a_last_report_is_mono,
                    records.valid && records.last_of_run && kind != KIND_SAMPLE,
                    kind == KIND_MONO, "report other than mono marked last")

endmodule

// ----- rtl/core/stereo_downmix_level_meter.sv -----
// Stereo downmix with level meter. A frame is accepted whenever the work queue
// (QUEUE_DEPTH entries) has room; frames that give no result never enter it. The
// back end pops one entry, sends the sample record of a kept frame and, for a
// frame with a last flag, the left, right and mono reports, each computed by the
// 32-step divider; it pops the next entry only when done with the last. A record
// sink that holds ready low stalls the back end.
module stereo_downmix_level_meter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  frame_if.sink       frames,
  record_if.source    records
);
  import sdlm_pkg::*;

  logic   push;
  entry_t push_data;
  logic   queue_full;
  logic   pop;
  entry_t pop_data;
  logic   queue_empty;

  sdlm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .frames     (frames),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  sdlm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  sdlm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (queue_empty),
    .pop_data (pop_data),
    .pop      (pop),
    .records  (records)
  );

endmodule

// ----- tb/stereo_downmix_level_meter_tb.sv -----
// self-checking testbench for the stereo downmix level meter
`timescale 1ns / 1ps

module stereo_downmix_level_meter_tb;
  import sdlm_pkg::*;

  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 216;
  localparam int PHASES       = 8;

  typedef struct {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               first_frame;
    logic               last_frame;
  } frame_item_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] value;
    logic signed [15:0] peak;
    logic [15:0]        average;
    logic [15:0]        kept;
    logic               full;
    logic               last_of_run;
  } record_item_t;

  typedef struct {
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic [31:0]        sum;
  } level_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [15:0] cfg_data;

  frame_if  frames ();
  record_if records ();

  stereo_downmix_level_meter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .frames   (frames),
    .records  (records)
  );

  frame_item_t  frame_backlog[$];
  record_item_t awaited_records[$];

  // meter state mirrored from the block
  level_t      left_level;
  level_t      right_level;
  level_t      mono_level;
  logic [15:0] kept_count;
  logic [15:0] capacity;

  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    if (error_count < 100) $display("%0t ns: mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic logic [16:0] magnitude(logic signed [15:0] s);
    int v;
    v = s;
    return 17'(v < 0 ? -v : v);
  endfunction

  function automatic level_t level_add(level_t lv, logic signed [15:0] s);
    level_t r;
    r = lv;
    if (s < r.low) r.low = s;
    if (s > r.high) r.high = s;
    r.sum = r.sum + 32'(magnitude(s));
    return r;
  endfunction

  function automatic record_item_t level_report(logic [1:0] kind, level_t lv, logic last_one);
    record_item_t r;
    r.kind        = kind;
    r.value       = lv.low;
    r.peak        = lv.high;
    r.average     = (kept_count != 0) ? 16'(lv.sum / 32'(kept_count)) : 16'd0;
    r.kept        = kept_count;
    r.full        = (kept_count >= capacity);
    r.last_of_run = last_one;
    return r;
  endfunction

  task automatic clear_levels();
    left_level  = '{low: 16'sd0, high: 16'sd0, sum: 32'd0};
    right_level = left_level;
    mono_level  = left_level;
    kept_count  = 16'd0;
  endtask

  // expected records for one accepted frame
  task automatic downmix_frame(frame_item_t f);
    logic signed [15:0] mono;
    record_item_t       r;
    if (f.first_frame) clear_levels();
    if (kept_count < capacity) begin
      mono        = (magnitude(f.left_sample) >= magnitude(f.right_sample)) ?
                    f.left_sample : f.right_sample;
      left_level  = level_add(left_level, f.left_sample);
      right_level = level_add(right_level, f.right_sample);
      mono_level  = level_add(mono_level, mono);
      kept_count  = kept_count + 16'd1;
      r.kind        = KIND_SAMPLE;
      r.value       = mono;
      r.peak        = 16'sd0;
      r.average     = 16'd0;
      r.kept        = kept_count;
      r.full        = (kept_count >= capacity);
      r.last_of_run = !f.last_frame;
      awaited_records.push_back(r);
    end
    if (f.last_frame) begin
      awaited_records.push_back(level_report(KIND_LEFT, left_level, 1'b0));
      awaited_records.push_back(level_report(KIND_RIGHT, right_level, 1'b0));
      awaited_records.push_back(level_report(KIND_MONO, mono_level, 1'b1));
    end
  endtask

  task automatic queue_frame(int l, int r, bit first_one, bit last_one);
    frame_item_t f;
    f.left_sample  = 16'(l);
    f.right_sample = 16'(r);
    f.first_frame  = first_one;
    f.last_frame   = last_one;
    frame_backlog.push_back(f);
  endtask

  function automatic int random_sample();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return -32768;
          1: return 32767;
          2: return 0;
          default: return -1;
        endcase
      end
      1: return int'($urandom_range(64)) - 32;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // wait for all items and records to pass, then let the back end drain
  task automatic settle();
    while (frame_backlog.size() != 0 || frames.valid || awaited_records.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [15:0] value);
    settle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    capacity = value;
  endtask

  // frame driver
  always @(posedge clk) begin : drive_frames
    frame_item_t f;
    if (rst) begin
      frames.valid <= 1'b0;
    end else begin
      if (frames.valid && frames.ready) begin
        f.left_sample  = frames.left_sample;
        f.right_sample = frames.right_sample;
        f.first_frame  = frames.first_frame;
        f.last_frame   = frames.last_frame;
        downmix_frame(f);
      end
      if (!frames.valid || frames.ready) begin
        if (frame_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          f = frame_backlog.pop_front();
          frames.valid        <= 1'b1;
          frames.left_sample  <= f.left_sample;
          frames.right_sample <= f.right_sample;
          frames.first_frame  <= f.first_frame;
          frames.last_frame   <= f.last_frame;
        end else begin
          frames.valid <= 1'b0;
        end
      end
    end
  end

  // record monitor
  always @(posedge clk) begin : watch_records
    record_item_t want;
    if (rst) begin
      records.ready <= 1'b0;
    end else begin
      records.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (records.valid && records.ready) begin
        if (awaited_records.size() == 0) begin
          report_mismatch("record arrived with none expected");
        end else begin
          want = awaited_records.pop_front();
          check_field("record_kind", records.record_kind, want.kind);
          check_field("value_or_minimum", records.value_or_minimum, want.value);
          check_field("peak_maximum", records.peak_maximum, want.peak);
          check_field("average_magnitude", records.average_magnitude, want.average);
          check_field("kept_frames", records.kept_frames, want.kept);
          check_field("buffer_full", records.buffer_full, want.full);
          check_field("last_of_run", records.last_of_run, want.last_of_run);
        end
      end
    end
  end

  // watchdog: only counts while work is outstanding
  always @(posedge clk) begin
    if (rst || (frames.valid && frames.ready) || (records.valid && records.ready) ||
        (frame_backlog.size() == 0 && !frames.valid && awaited_records.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int queued;
    int run_len;
    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_data             = 16'd0;
    frames.valid         = 1'b0;
    frames.left_sample   = 16'sd0;
    frames.right_sample  = 16'sd0;
    frames.first_frame   = 1'b0;
    frames.last_frame    = 1'b0;
    records.ready        = 1'b0;
    error_count          = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    stall_cycles         = 0;
    capacity             = CAPACITY_RESET;
    clear_levels();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: extremes, ties, most negative sample
    queue_frame(32767, -32768, 1, 0);
    queue_frame(-32768, 32767, 0, 0);
    queue_frame(100, -100, 0, 0);
    queue_frame(-7, 7, 0, 0);
    queue_frame(0, 0, 0, 1);
    queue_frame(-1, 1, 0, 1);
    queue_frame(5, -3, 1, 1);

    // fill up, then dropped frames with and without last
    write_capacity(16'd3);
    queue_frame(10, 20, 1, 0);
    queue_frame(-30, 5, 0, 0);
    queue_frame(1, 2, 0, 0);
    queue_frame(32767, 32767, 0, 0);
    queue_frame(-32768, -32768, 0, 1);

    // capacity lowered below the count
    write_capacity(16'd65535);
    queue_frame(1, 1, 1, 0);
    queue_frame(200, -300, 0, 0);
    queue_frame(-32768, 0, 0, 0);
    write_capacity(16'd2);
    queue_frame(9, 9, 0, 0);
    queue_frame(9, 9, 0, 1);
    queue_frame(-9, 4, 1, 1);

    // capacity zero: nothing kept, average zero
    write_capacity(16'd0);
    queue_frame(123, -456, 1, 1);
    queue_frame(1, 1, 0, 0);

    write_capacity(16'd1);
    queue_frame(-2, 3, 1, 0);
    queue_frame(4, 4, 0, 1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(3))
        0: write_capacity(16'($urandom_range(4, 1)));
        1: write_capacity(16'($urandom_range(12, 5)));
        2: write_capacity(16'd65535);
        default: write_capacity(16'($urandom_range(65535, 1)));
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      queued = 0;
      while (queued < RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(9) < 8) begin
          // recording: first item opens it, last item closes it
          run_len = $urandom_range(10, 1);
          for (int i = 0; i < run_len; i++)
            queue_frame(random_sample(), random_sample(), i == 0, i == run_len - 1);
          queued += run_len;
        end else begin
          queue_frame(random_sample(), random_sample(), $urandom_range(1), $urandom_range(1));
          queued++;
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sdlm_pkg.sv
rtl/core/sdlm_if.sv
rtl/core/sdlm_front.sv
rtl/core/sdlm_queue.sv
rtl/core/sdlm_div.sv
rtl/core/sdlm_back.sv
rtl/core/stereo_downmix_level_meter.sv
tb/stereo_downmix_level_meter_tb.sv
